### hw/rtl/assert_macros.svh
// Assertion macros for the plotter RTL; included by turtle_grid_plotter_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define TGP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tgp assertion failed");
// Check that a condition never holds outside reset.
`define TGP_ASSERT_NEVER(label, cond) \
    `TGP_ASSERT(label, !(cond))
`else
`define TGP_ASSERT(label, prop)
`define TGP_ASSERT_NEVER(label, cond)
`endif
`endif

### hw/rtl/tgp_pkg.sv
// Package with command codes, headings and transfer types of the grid plotter.
package tgp_pkg;

    localparam int GRID_SIZE_DEF = 32;

    localparam logic [2:0] OP_PEN_UP   = 3'd0;
    localparam logic [2:0] OP_PEN_DOWN = 3'd1;
    localparam logic [2:0] OP_RIGHT    = 3'd2;
    localparam logic [2:0] OP_LEFT     = 3'd3;
    localparam logic [2:0] OP_MOVE     = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [1:0] HEAD_EAST  = 2'd0;
    localparam logic [1:0] HEAD_SOUTH = 2'd1;
    localparam logic [1:0] HEAD_WEST  = 2'd2;
    localparam logic [1:0] HEAD_NORTH = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] steps;
        logic [4:0] row_select;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0]  row_pos;
        logic [4:0]  col_pos;
        logic [1:0]  heading;
        logic        pen_is_down;
        logic [31:0] row_bits;
        logic        halted;
    } res_item_t;

endpackage

### hw/rtl/turtle_grid_plotter_unit.sv
// Top level of the turtle grid plotter: command sequencer and result register.
//
// Usage: commands arrive on cmd (cmd_valid / cmd_stall); every command yields
// exactly one result on res (res_valid / res_stall), in command order. A
// transfer happens on a rising clk edge with valid high and stall low.
// One command is worked on at a time; cmd_stall is high while it runs.
// States a command passes through after it is taken, before the result state:
//   pen up, turns, stop, zero-step move, any command after stop: none
//   pen down, read row: mark or read state (one read-modify-write or read of RAM)
//   move of n steps: move state for min(n, steps to the edge) steps; with the pen
//   down, each step writes back the cell of the step before via the single write
//   port of the row RAM, and a move ends early once the turtle sits at the edge.
// Commands do not overlap: the next command is taken only after the result of
// the one before is loaded, which waits while the result register is not free.
// The next command is taken while a result still waits on res; when the
// receiver stalls, the finished result is held until the one in the result
// register has gone.
// Reset clears turtle position, heading, pen and stop flag at once; the grid
// rows are cleared by per-row valid bits, so no clearing pass is needed and
// the unit comes out of reset idle, ready for the first command.
`include "assert_macros.svh"
module turtle_grid_plotter_unit import tgp_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    localparam int RW = $clog2(GRID_SIZE);
    localparam logic [RW-1:0] LAST_POS = RW'(GRID_SIZE - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MARK = 5'b00010,
        S_READ = 5'b00100,
        S_MOVE = 5'b01000,
        S_POST = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [RW-1:0]   col_reg, col_next;
    logic [1:0]      head_reg, head_next;
    logic            pen_reg, pen_next;
    logic            halt_reg, halt_next;
    logic [7:0]      steps_reg, steps_next;
    logic            pend_reg, pend_next;
    logic [RW-1:0]   pend_row_reg, pend_row_next;
    logic [RW-1:0]   pend_col_reg, pend_col_next;
    logic            sel_ok_reg, sel_ok_next;
    logic [31:0]     bits_reg, bits_next;
    logic            res_vld_reg, res_vld_next;
    res_item_t       res_reg, res_next;

    logic            rd_en;
    logic [RW-1:0]   rd_row;
    logic [GRID_SIZE-1:0] rd_data;
    logic            wr_en;
    logic [GRID_SIZE-1:0] wr_data;
    logic [63:0]     row_wide;
    logic [6:0]      sel_ext;
    logic [RW-1:0]   new_row;
    logic [RW-1:0]   new_col;
    logic            at_edge;
    logic            can_step;
    logic            res_free;
    logic [7:0]      row_wide_pos;
    logic [7:0]      col_wide_pos;

    tgp_grid #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_row  (pend_row_reg),
        .wr_data (wr_data)
    );

    // write back the pending cell: pen-down mark or the previous move step
    assign wr_en   = (state_reg == S_MARK) || ((state_reg == S_MOVE) && pend_reg);
    assign wr_data = rd_data | ({{(GRID_SIZE-1){1'b0}}, 1'b1} << pend_col_reg);

    assign row_wide = 64'(rd_data);
    assign sel_ext  = 7'(cmd.row_select);

    // next cell in the heading and whether the turtle sits against that edge
    always_comb
    begin
        new_row = row_reg;
        new_col = col_reg;
        at_edge = 1'b0;
        case (head_reg)
            HEAD_EAST:
            begin
                new_col = col_reg + RW'(1);
                at_edge = (col_reg == LAST_POS);
            end
            HEAD_SOUTH:
            begin
                new_row = row_reg + RW'(1);
                at_edge = (row_reg == LAST_POS);
            end
            HEAD_WEST:
            begin
                new_col = col_reg - RW'(1);
                at_edge = (col_reg == '0);
            end
            default:
            begin
                new_row = row_reg - RW'(1);
                at_edge = (row_reg == '0);
            end
        endcase
    end

    // a clamped step leaves the turtle on a cell that is already marked, so stop there
    assign can_step = (steps_reg != 8'd0) && !at_edge;
    assign res_free = !res_vld_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);

    assign row_wide_pos = 8'(row_reg);
    assign col_wide_pos = 8'(col_reg);

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        head_next     = head_reg;
        pen_next      = pen_reg;
        halt_next     = halt_reg;
        steps_next    = steps_reg;
        pend_next     = pend_reg;
        pend_row_next = pend_row_reg;
        pend_col_next = pend_col_reg;
        sel_ok_next   = sel_ok_reg;
        bits_next     = bits_reg;
        res_next      = res_reg;
        res_vld_next  = res_vld_reg;
        rd_en         = 1'b0;
        rd_row        = row_reg;

        // drop the result once the receiver takes it
        if (res_vld_reg && !res_stall)
        begin
            res_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    bits_next  = '0;
                    state_next = S_POST;
                    if (!halt_reg)
                    begin
                        case (cmd.operation)
                            OP_PEN_UP:
                            begin
                                pen_next = 1'b0;
                            end
                            OP_PEN_DOWN:
                            begin
                                pen_next      = 1'b1;
                                rd_en         = 1'b1;
                                rd_row        = row_reg;
                                pend_row_next = row_reg;
                                pend_col_next = col_reg;
                                state_next    = S_MARK;
                            end
                            OP_RIGHT:
                            begin
                                head_next = head_reg + 2'd1;
                            end
                            OP_LEFT:
                            begin
                                head_next = head_reg - 2'd1;
                            end
                            OP_MOVE:
                            begin
                                steps_next = cmd.steps;
                                if (cmd.steps != 8'd0)
                                begin
                                    state_next = S_MOVE;
                                end
                            end
                            OP_READ:
                            begin
                                rd_en       = 1'b1;
                                rd_row      = sel_ext[RW-1:0];
                                sel_ok_next = (sel_ext < 7'(GRID_SIZE));
                                state_next  = S_READ;
                            end
                            default:
                            begin
                                halt_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_MARK:
            begin
                state_next = S_POST;
            end
            S_READ:
            begin
                bits_next  = sel_ok_reg ? row_wide[31:0] : '0;
                state_next = S_POST;
            end
            S_MOVE:
            begin
                if (can_step)
                begin
                    steps_next = steps_reg - 8'd1;
                    row_next   = new_row;
                    col_next   = new_col;
                    pend_next  = pen_reg;
                    if (pen_reg)
                    begin
                        // fetch the landing row; it is written back next cycle
                        rd_en         = 1'b1;
                        rd_row        = new_row;
                        pend_row_next = new_row;
                        pend_col_next = new_col;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (res_free)
                begin
                    res_vld_next         = 1'b1;
                    res_next.row_pos     = row_wide_pos[4:0];
                    res_next.col_pos     = col_wide_pos[4:0];
                    res_next.heading     = head_reg;
                    res_next.pen_is_down = pen_reg;
                    res_next.row_bits    = bits_reg;
                    res_next.halted      = halt_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            head_reg    <= HEAD_EAST;
            pen_reg     <= 1'b0;
            halt_reg    <= 1'b0;
            steps_reg   <= '0;
            pend_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            head_reg    <= head_next;
            pen_reg     <= pen_next;
            halt_reg    <= halt_next;
            steps_reg   <= steps_next;
            pend_reg    <= pend_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_row_reg <= pend_row_next;
        pend_col_reg <= pend_col_next;
        sel_ok_reg   <= sel_ok_next;
        bits_reg     <= bits_next;
        res_reg      <= res_next;
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    `TGP_ASSERT(a_halt_sticky, halt_reg |=> halt_reg)
    `TGP_ASSERT(a_pend_in_move, pend_reg |-> (state_reg == S_MOVE))
    `TGP_ASSERT_NEVER(a_pos_off_grid, (row_reg > LAST_POS) || (col_reg > LAST_POS))
    `TGP_ASSERT(a_step_count, ((state_reg == S_MOVE) && can_step) |=> (steps_reg == $past(steps_reg) - 8'd1))

endmodule

### hw/rtl/tgp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tgp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem_reg[raddr];
        end
    end

    assign rdata = q_reg;

endmodule

### hw/rtl/tgp_grid.sv
// Grid store: row RAM, per-row valid bits for reset clearing, write forwarding.
module tgp_grid import tgp_pkg::*; #(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(GRID_SIZE)-1:0] rd_row,
    output logic [GRID_SIZE-1:0]         rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(GRID_SIZE)-1:0] wr_row,
    input  logic [GRID_SIZE-1:0]         wr_data
);

    logic [GRID_SIZE-1:0] ram_q;
    logic [GRID_SIZE-1:0] vld_reg;
    logic [GRID_SIZE-1:0] vld_next;
    logic                 vld_q_reg;
    logic                 vld_q_next;
    logic                 fwd_hit_reg;
    logic                 fwd_hit_next;
    logic [GRID_SIZE-1:0] fwd_data_reg;

    tgp_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_row),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_row),
        .rdata (ram_q)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_row] = 1'b1;
        end
        vld_q_next   = rd_en ? vld_reg[rd_row] : vld_q_reg;
        // same-row write in the read cycle: RAM gives old data, forward the new row
        fwd_hit_next = rd_en && wr_en && (rd_row == wr_row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_q_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            vld_q_reg   <= vld_q_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
    end

    // rows never written since reset read as cleared
    assign rd_data = fwd_hit_reg ? fwd_data_reg : (vld_q_reg ? ram_q : '0);

endmodule
